@@ rtl/iwss_pkg.sv @@
// shared types and constants for the imu window sample selector
package iwss_pkg;

  localparam int BufferDepth = 32;
  localparam int MedianPairs = 10;
  localparam int MaxOut      = 32;
  localparam int ResW        = 6;
  localparam int CfgW        = 40;
  localparam int CfgIdxW     = 2;
  localparam logic [CfgW-1:0] ResetPeriod = 40'd1000000;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MIN_MARGIN     = 2'd0,
    CFG_MAX_MARGIN     = 2'd1,
    CFG_DEFAULT_PERIOD = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_ADD_INIT,
    OP_ADD_RD,
    OP_ADD_CMP,
    OP_ADD_WR,
    OP_P_INIT,
    OP_RD,
    OP_P_USE,
    OP_MARGIN,
    OP_S_USE,
    OP_RANGE,
    OP_E_USE,
    OP_PRUNE,
    OP_FINAL
  } dp_op_e;

  typedef struct packed {
    logic signed [63:0] stamp;
    logic [2:0][31:0]   acc;
    logic [2:0][31:0]   gyr;
  } entry_t;

  typedef struct packed {
    dp_op_e op;
  } cmd_t;

  typedef struct packed {
    logic is_add;
    logic run_ok;
    logic pos_zero;
    logic rd_gt;
    logic p_skip;
    logic idx_last;
    logic idx_at_hi;
    logic out_free;
    logic e_stall;
  } status_t;

endpackage

@@ rtl/iwss_dp.sv @@
// datapath: sample buffer memory, period sorter, margin and selection registers
module iwss_dp #(
  parameter int DEPTH = iwss_pkg::BufferDepth,
  parameter int PAIRS = iwss_pkg::MedianPairs
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [iwss_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [iwss_pkg::CfgW-1:0]         cfg_data_i,
  input  logic                              operation_i,
  input  logic signed [63:0]                sample_stamp_i,
  input  logic signed [63:0]                window_start_i,
  input  logic signed [63:0]                window_end_i,
  input  logic [31:0]                       acc_x_i,
  input  logic [31:0]                       acc_y_i,
  input  logic [31:0]                       acc_z_i,
  input  logic [31:0]                       gyr_x_i,
  input  logic [31:0]                       gyr_y_i,
  input  logic [31:0]                       gyr_z_i,
  input  iwss_pkg::cmd_t                    cmd_i,
  output iwss_pkg::status_t                 status_o,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic signed [63:0]                out_stamp_o,
  output logic [31:0]                       out_acc_x_o,
  output logic [31:0]                       out_acc_y_o,
  output logic [31:0]                       out_acc_z_o,
  output logic [31:0]                       out_gyr_x_o,
  output logic [31:0]                       out_gyr_y_o,
  output logic [31:0]                       out_gyr_z_o,
  output logic                              empty_result_o,
  output logic                              last_of_run_o
);

  localparam int IW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);
  localparam int NW = $clog2(PAIRS + 1);
  localparam int MW = (PAIRS > 1) ? $clog2(PAIRS) : 1;
  localparam logic [IW:0]   DepthS = (IW + 1)'(DEPTH);
  localparam logic [IW-1:0] DepthC = IW'(DEPTH);
  localparam logic [IW-1:0] PairsC = IW'(PAIRS);

  logic [iwss_pkg::CfgW-1:0] min_q, max_q, defp_q;
  logic [AW-1:0]             head_q, head_d;
  logic [IW-1:0]             cnt_q, cnt_d, idx_q, idx_d;
  iwss_pkg::entry_t          new_q;
  logic signed [63:0]        start_q, end_q;
  iwss_pkg::entry_t          mem [DEPTH];
  iwss_pkg::entry_t          rd_q;
  logic [63:0]               d_q [PAIRS];
  logic [63:0]               d_d [PAIRS];
  logic [63:0]               lower [PAIRS];
  logic [NW-1:0]             n_q;
  logic [63:0]               prev_q;
  logic                      prev_vld_q;
  logic [63:0]               margin_q;
  logic [IW-1:0]             nb_q, nk_q, hi_q;
  logic signed [63:0]        bstamp_q, astamp_q;
  logic                      aseen_q;
  iwss_pkg::entry_t          pend_q, out_q;
  logic                      pend_vld_q, out_vld_q, out_empty_q, out_last_q;
  logic [iwss_pkg::ResW-1:0] res_q;

  logic                      mem_we, mem_re;
  logic [IW-1:0]             wlog, rlog;
  iwss_pkg::entry_t          wdata;
  logic [63:0]               dt;
  logic                      ins;
  logic [NW-1:0]             mid;
  logic [63:0]               per, m2, m1, mfin, minw, maxw;
  logic [IW-1:0]             cm1, pairs;
  logic                      dup, full, take, out_free, e_stall, bok, aok;

  function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] b, logic [IW-1:0] off);
    logic [IW:0] s;
    s = {{(IW + 1 - AW){1'b0}}, b} + {1'b0, off};
    if (s >= DepthS) begin
      s = s - DepthS;
    end
    return s[AW-1:0];
  endfunction

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q  <= '0;
      max_q  <= '0;
      defp_q <= iwss_pkg::ResetPeriod;
    end else if (cfg_we_i) begin
      unique case (iwss_pkg::cfg_idx_e'(cfg_idx_i))
        iwss_pkg::CFG_MIN_MARGIN:     min_q  <= cfg_data_i;
        iwss_pkg::CFG_MAX_MARGIN:     max_q  <= cfg_data_i;
        iwss_pkg::CFG_DEFAULT_PERIOD: defp_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // buffer memory access
  always_comb begin
    mem_we = 1'b0;
    mem_re = 1'b0;
    wlog   = idx_q;
    rlog   = idx_q;
    wdata  = new_q;
    case (cmd_i.op)
      iwss_pkg::OP_ADD_RD: begin
        mem_re = 1'b1;
        rlog   = idx_q - 1'b1;
      end
      iwss_pkg::OP_RD: mem_re = 1'b1;
      iwss_pkg::OP_ADD_CMP: begin
        mem_we = status_o.rd_gt;
        wdata  = rd_q;
      end
      iwss_pkg::OP_ADD_WR: mem_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wrap_add(head_q, wlog)] <= wdata;
    end
    if (mem_re) begin
      rd_q <= mem[wrap_add(head_q, rlog)];
    end
  end

  // sorted insertion of a positive delta
  assign dt  = rd_q.stamp - prev_q;
  assign ins = prev_vld_q && ($signed(rd_q.stamp) > $signed(prev_q));

  always_comb begin
    lower[0] = '0;
    for (int j = 1; j < PAIRS; j++) begin
      lower[j] = d_q[j-1];
    end
    for (int j = 0; j < PAIRS; j++) begin
      d_d[j] = d_q[j];
      if ((NW'(j) == n_q) || ((NW'(j) < n_q) && (d_q[j] > dt))) begin
        d_d[j] = ((j > 0) && (lower[j] > dt)) ? lower[j] : dt;
      end
    end
  end

  // margin
  assign mid  = n_q >> 1;
  assign minw = {{(64 - iwss_pkg::CfgW){1'b0}}, min_q};
  assign maxw = {{(64 - iwss_pkg::CfgW){1'b0}}, max_q};
  assign per  = (n_q == '0) ? {{(64 - iwss_pkg::CfgW){1'b0}}, defp_q} : d_q[mid[MW-1:0]];
  assign m2   = per[63] ? '1 : {per[62:0], 1'b0};
  assign m1   = (minw > m2) ? minw : m2;
  assign mfin = ((max_q != '0) && (m1 > maxw)) ? maxw : m1;

  assign cm1   = cnt_q - 1'b1;
  assign pairs = (32'(cm1) > PAIRS) ? PairsC : cm1;

  assign bok = (nb_q != '0) && ((start_q - bstamp_q) <= margin_q);
  assign aok = aseen_q && ((astamp_q - end_q) <= margin_q);

  assign out_free = !out_vld_q || out_ready_i;
  assign dup      = pend_vld_q && (rd_q.stamp == pend_q.stamp);
  assign full     = (res_q == iwss_pkg::ResW'(iwss_pkg::MaxOut));
  assign take     = !dup && !full;
  assign e_stall  = take && pend_vld_q && !out_free;

  assign status_o.is_add    = !operation_i;
  assign status_o.run_ok    = (cnt_q != '0) && (end_q >= start_q);
  assign status_o.pos_zero  = (idx_q == '0);
  assign status_o.rd_gt     = $signed(rd_q.stamp) > $signed(new_q.stamp);
  assign status_o.p_skip    = (cnt_q < IW'(2));
  assign status_o.idx_last  = (idx_q == cm1);
  assign status_o.idx_at_hi = (idx_q == hi_q);
  assign status_o.out_free  = out_free;
  assign status_o.e_stall   = e_stall;

  always_comb begin
    head_d = head_q;
    cnt_d  = cnt_q;
    idx_d  = idx_q;
    case (cmd_i.op)
      iwss_pkg::OP_ADD_INIT: begin
        if (cnt_q == DepthC) begin
          head_d = wrap_add(head_q, IW'(1));
          cnt_d  = cm1;
          idx_d  = cm1;
        end else begin
          idx_d = cnt_q;
        end
      end
      iwss_pkg::OP_ADD_CMP: if (status_o.rd_gt) idx_d = idx_q - 1'b1;
      iwss_pkg::OP_ADD_WR:  cnt_d = cnt_q + 1'b1;
      iwss_pkg::OP_P_INIT:  idx_d = cm1 - pairs;
      iwss_pkg::OP_P_USE,
      iwss_pkg::OP_S_USE:   idx_d = idx_q + 1'b1;
      iwss_pkg::OP_MARGIN:  idx_d = '0;
      iwss_pkg::OP_RANGE:   idx_d = bok ? nb_q - 1'b1 : nb_q;
      iwss_pkg::OP_E_USE:   if (!e_stall) idx_d = idx_q + 1'b1;
      iwss_pkg::OP_PRUNE: begin
        if (nk_q > IW'(1)) begin
          head_d = wrap_add(head_q, nk_q - 1'b1);
          cnt_d  = cnt_q - (nk_q - 1'b1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q     <= '0;
      cnt_q      <= '0;
      idx_q      <= '0;
      n_q        <= '0;
      prev_vld_q <= 1'b0;
      aseen_q    <= 1'b0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
      res_q      <= '0;
    end else begin
      head_q <= head_d;
      cnt_q  <= cnt_d;
      idx_q  <= idx_d;
      if (out_vld_q && out_ready_i) begin
        out_vld_q <= 1'b0;
      end
      case (cmd_i.op)
        iwss_pkg::OP_LOAD: pend_vld_q <= 1'b0;
        iwss_pkg::OP_P_INIT: begin
          n_q        <= '0;
          prev_vld_q <= 1'b0;
        end
        iwss_pkg::OP_P_USE: begin
          prev_vld_q <= 1'b1;
          if (ins) begin
            n_q <= n_q + 1'b1;
          end
        end
        iwss_pkg::OP_MARGIN: aseen_q <= 1'b0;
        iwss_pkg::OP_S_USE: begin
          if ($signed(rd_q.stamp) > end_q) begin
            aseen_q <= 1'b1;
          end
        end
        iwss_pkg::OP_RANGE: res_q <= '0;
        iwss_pkg::OP_E_USE: begin
          if (take && !e_stall) begin
            pend_vld_q <= 1'b1;
            res_q      <= res_q + 1'b1;
            if (pend_vld_q) begin
              out_vld_q <= 1'b1;
            end
          end
        end
        iwss_pkg::OP_FINAL: if (out_free) out_vld_q <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      iwss_pkg::OP_LOAD: begin
        new_q.stamp <= sample_stamp_i;
        new_q.acc   <= {acc_z_i, acc_y_i, acc_x_i};
        new_q.gyr   <= {gyr_z_i, gyr_y_i, gyr_x_i};
        start_q     <= window_start_i[63] ? '0 : window_start_i;
        end_q       <= window_end_i;
      end
      iwss_pkg::OP_P_USE: begin
        prev_q <= rd_q.stamp;
        if (ins) begin
          d_q <= d_d;
        end
      end
      iwss_pkg::OP_MARGIN: begin
        margin_q <= mfin;
        nb_q     <= '0;
        nk_q     <= '0;
      end
      iwss_pkg::OP_S_USE: begin
        if ($signed(rd_q.stamp) <= start_q) begin
          nb_q     <= idx_q + 1'b1;
          bstamp_q <= rd_q.stamp;
        end
        if ($signed(rd_q.stamp) <= end_q) begin
          nk_q <= idx_q + 1'b1;
        end else if (!aseen_q) begin
          astamp_q <= rd_q.stamp;
        end
      end
      iwss_pkg::OP_RANGE: hi_q <= aok ? nk_q + 1'b1 : nk_q;
      iwss_pkg::OP_E_USE: begin
        if (take && !e_stall) begin
          pend_q <= rd_q;
          if (pend_vld_q) begin
            out_q       <= pend_q;
            out_empty_q <= 1'b0;
            out_last_q  <= 1'b0;
          end
        end
      end
      iwss_pkg::OP_FINAL: begin
        if (out_free) begin
          out_q       <= pend_vld_q ? pend_q : '0;
          out_empty_q <= !pend_vld_q;
          out_last_q  <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o    = out_vld_q;
  assign out_stamp_o    = out_q.stamp;
  assign out_acc_x_o    = out_q.acc[0];
  assign out_acc_y_o    = out_q.acc[1];
  assign out_acc_z_o    = out_q.acc[2];
  assign out_gyr_x_o    = out_q.gyr[0];
  assign out_gyr_y_o    = out_q.gyr[1];
  assign out_gyr_z_o    = out_q.gyr[2];
  assign empty_result_o = out_empty_q;
  assign last_of_run_o  = out_last_q;

endmodule

@@ rtl/iwss_ctrl.sv @@
// controller state machine sequencing add and assign transactions
module iwss_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  iwss_pkg::status_t status_i,
  output iwss_pkg::cmd_t    cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_ADD_INIT, S_ADD_RD, S_ADD_CMP, S_ADD_WR, S_A_CHK,
    S_P_INIT, S_P_RD, S_P_USE, S_MARGIN, S_S_RD, S_S_USE, S_RANGE,
    S_E_CHK, S_E_RD, S_E_USE, S_PRUNE, S_FINAL
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d   = state_q;
    cmd_o.op  = iwss_pkg::OP_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = iwss_pkg::OP_LOAD;
          state_d  = status_i.is_add ? S_ADD_INIT : S_A_CHK;
        end
      end
      S_ADD_INIT: begin
        cmd_o.op = iwss_pkg::OP_ADD_INIT;
        state_d  = S_ADD_RD;
      end
      S_ADD_RD: begin
        if (status_i.pos_zero) begin
          state_d = S_ADD_WR;
        end else begin
          cmd_o.op = iwss_pkg::OP_ADD_RD;
          state_d  = S_ADD_CMP;
        end
      end
      S_ADD_CMP: begin
        cmd_o.op = iwss_pkg::OP_ADD_CMP;
        state_d  = status_i.rd_gt ? S_ADD_RD : S_ADD_WR;
      end
      S_ADD_WR: begin
        cmd_o.op = iwss_pkg::OP_ADD_WR;
        state_d  = S_IDLE;
      end
      S_A_CHK:  state_d = status_i.run_ok ? S_P_INIT : S_FINAL;
      S_P_INIT: begin
        cmd_o.op = iwss_pkg::OP_P_INIT;
        state_d  = status_i.p_skip ? S_MARGIN : S_P_RD;
      end
      S_P_RD: begin
        cmd_o.op = iwss_pkg::OP_RD;
        state_d  = S_P_USE;
      end
      S_P_USE: begin
        cmd_o.op = iwss_pkg::OP_P_USE;
        state_d  = status_i.idx_last ? S_MARGIN : S_P_RD;
      end
      S_MARGIN: begin
        cmd_o.op = iwss_pkg::OP_MARGIN;
        state_d  = S_S_RD;
      end
      S_S_RD: begin
        cmd_o.op = iwss_pkg::OP_RD;
        state_d  = S_S_USE;
      end
      S_S_USE: begin
        cmd_o.op = iwss_pkg::OP_S_USE;
        state_d  = status_i.idx_last ? S_RANGE : S_S_RD;
      end
      S_RANGE: begin
        cmd_o.op = iwss_pkg::OP_RANGE;
        state_d  = S_E_CHK;
      end
      S_E_CHK: state_d = status_i.idx_at_hi ? S_PRUNE : S_E_RD;
      S_E_RD: begin
        cmd_o.op = iwss_pkg::OP_RD;
        state_d  = S_E_USE;
      end
      S_E_USE: begin
        cmd_o.op = iwss_pkg::OP_E_USE;
        state_d  = status_i.e_stall ? S_E_USE : S_E_CHK;
      end
      S_PRUNE: begin
        cmd_o.op = iwss_pkg::OP_PRUNE;
        state_d  = S_FINAL;
      end
      S_FINAL: begin
        cmd_o.op = iwss_pkg::OP_FINAL;
        state_d  = status_i.out_free ? S_IDLE : S_FINAL;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule

@@ rtl/imu_window_sample_selector.sv @@
// top level of the imu window sample selector
// Input channel (in_valid_i/in_ready_o) carries one transaction: an add
// (operation 0) or an assign (operation 1). Output channel (out_valid_o/
// out_ready_i) carries the selected samples of an assign, last_of_run_o on
// the final one; an assign that selects nothing gives one empty_result_o.
// Config writes (cfg_we_i, cfg_idx_i, cfg_data_i) take effect at once; the user
// makes them only while the block is idle, which the block does not enforce.
// Samples live in a single-port circular buffer; an entry is read in a read
// state, then used. An add drops the oldest entry when full, shifts later
// entries up one place by a read and a compare each, then writes the sample.
// An assign reads the newest median pairs, scans all entries for the margin
// and window, then walks entries for emission; pruning is a head pointer move.
// One transaction is in work at a time. The result register frees the engine:
// a stalled receiver only holds it when a result must go to a full register.
// Reset empties the buffer and loads the register defaults; no clearing pass.
module imu_window_sample_selector #(
  parameter int DEPTH = iwss_pkg::BufferDepth,
  parameter int PAIRS = iwss_pkg::MedianPairs
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [iwss_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [iwss_pkg::CfgW-1:0]    cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         operation_i,
  input  logic signed [63:0]           sample_stamp_i,
  input  logic signed [63:0]           window_start_i,
  input  logic signed [63:0]           window_end_i,
  input  logic [31:0]                  acc_x_i,
  input  logic [31:0]                  acc_y_i,
  input  logic [31:0]                  acc_z_i,
  input  logic [31:0]                  gyr_x_i,
  input  logic [31:0]                  gyr_y_i,
  input  logic [31:0]                  gyr_z_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [63:0]           out_stamp_o,
  output logic [31:0]                  out_acc_x_o,
  output logic [31:0]                  out_acc_y_o,
  output logic [31:0]                  out_acc_z_o,
  output logic [31:0]                  out_gyr_x_o,
  output logic [31:0]                  out_gyr_y_o,
  output logic [31:0]                  out_gyr_z_o,
  output logic                         empty_result_o,
  output logic                         last_of_run_o
);

  iwss_pkg::cmd_t    cmd;
  iwss_pkg::status_t status;

  iwss_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  iwss_dp #(
    .DEPTH (DEPTH),
    .PAIRS (PAIRS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .operation_i    (operation_i),
    .sample_stamp_i (sample_stamp_i),
    .window_start_i (window_start_i),
    .window_end_i   (window_end_i),
    .acc_x_i        (acc_x_i),
    .acc_y_i        (acc_y_i),
    .acc_z_i        (acc_z_i),
    .gyr_x_i        (gyr_x_i),
    .gyr_y_i        (gyr_y_i),
    .gyr_z_i        (gyr_z_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .out_stamp_o    (out_stamp_o),
    .out_acc_x_o    (out_acc_x_o),
    .out_acc_y_o    (out_acc_y_o),
    .out_acc_z_o    (out_acc_z_o),
    .out_gyr_x_o    (out_gyr_x_o),
    .out_gyr_y_o    (out_gyr_y_o),
    .out_gyr_z_o    (out_gyr_z_o),
    .empty_result_o (empty_result_o),
    .last_of_run_o  (last_of_run_o)
  );

endmodule

@@ rtl/iwss_checker.sv @@
// port checker for the imu window sample selector and its bind
module iwss_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         cfg_we_i,
  input logic [iwss_pkg::CfgIdxW-1:0] cfg_idx_i,
  input logic [iwss_pkg::CfgW-1:0]    cfg_data_i,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic                         operation_i,
  input logic signed [63:0]           sample_stamp_i,
  input logic signed [63:0]           window_start_i,
  input logic signed [63:0]           window_end_i,
  input logic [31:0]                  acc_x_i,
  input logic [31:0]                  acc_y_i,
  input logic [31:0]                  acc_z_i,
  input logic [31:0]                  gyr_x_i,
  input logic [31:0]                  gyr_y_i,
  input logic [31:0]                  gyr_z_i,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic signed [63:0]           out_stamp_o,
  input logic [31:0]                  out_acc_x_o,
  input logic [31:0]                  out_acc_y_o,
  input logic [31:0]                  out_acc_z_o,
  input logic [31:0]                  out_gyr_x_o,
  input logic [31:0]                  out_gyr_y_o,
  input logic [31:0]                  out_gyr_z_o,
  input logic                         empty_result_o,
  input logic                         last_of_run_o
);

  // a stalled result transaction holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_stamp_o))
    else $error("stalled result dropped or changed");

  // an empty result closes its run and carries zeros
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && empty_result_o |-> last_of_run_o && (out_stamp_o == '0))
    else $error("empty result malformed");

  // an add produces no result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !operation_i && !out_valid_o |=> !out_valid_o)
    else $error("add produced a result");

  // one transaction in work at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second transaction taken while busy");

endmodule

bind imu_window_sample_selector iwss_checker u_iwss_checker (.*);

@@ test/tb.sv @@
// testbench for the imu window sample selector: directed table, then random add/assign runs
`timescale 1ns/1ps
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import iwss_pkg::*;

  localparam bit OP_ADD    = 1'b0;
  localparam bit OP_ASSIGN = 1'b1;

  typedef struct {
    bit               op;
    logic signed [63:0] stamp;
    logic signed [63:0] win_lo;
    logic signed [63:0] win_hi;
    logic [31:0]      w [6];
  } imu_item_t;

  typedef struct {
    logic [63:0] stamp;
    logic [31:0] w [6];
    bit          empty;
    bit          last;
  } sel_sample_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = CFG_MIN_MARGIN;
  logic [CfgW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic operation_i = 1'b0;
  logic signed [63:0] sample_stamp_i = '0, window_start_i = '0, window_end_i = '0;
  logic [31:0] acc_x_i = '0, acc_y_i = '0, acc_z_i = '0;
  logic [31:0] gyr_x_i = '0, gyr_y_i = '0, gyr_z_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [63:0] out_stamp_o;
  logic [31:0] out_acc_x_o, out_acc_y_o, out_acc_z_o, out_gyr_x_o, out_gyr_y_o, out_gyr_z_o;
  logic empty_result_o, last_of_run_o;

  imu_window_sample_selector dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  logic signed [63:0] buf_stamp [BufferDepth];
  logic [31:0]        buf_words [BufferDepth][6];
  int                 buf_fill = 0;
  logic [63:0]        min_mgn = '0, max_mgn = '0, dflt_period = 64'(ResetPeriod);

  sel_sample_t pending_samples[$];
  int  mismatches = 0;
  int  sample_count = 0;
  int  assign_count = 0;
  int  add_count = 0;
  bit  no_gaps = 1'b0;
  bit  hold_go = 1'b0;

  function automatic void drop_oldest(int n);
    for (int i = 0; i + n < buf_fill; i++) begin
      buf_stamp[i] = buf_stamp[i + n];
      buf_words[i] = buf_words[i + n];
    end
    buf_fill -= n;
  endfunction

  function automatic void store_sample(imu_item_t it);
    int pos;
    if (buf_fill >= BufferDepth) drop_oldest(1);
    pos = buf_fill;
    while (pos > 0 && buf_stamp[pos - 1] > it.stamp) pos--;
    for (int i = buf_fill; i > pos; i--) begin
      buf_stamp[i] = buf_stamp[i - 1];
      buf_words[i] = buf_words[i - 1];
    end
    buf_stamp[pos] = it.stamp;
    buf_words[pos] = it.w;
    buf_fill++;
  endfunction

  function automatic logic [63:0] median_period();
    logic [63:0] deltas[$];
    int pairs;
    if (buf_fill < 2) return dflt_period;
    pairs = (buf_fill - 1 > MedianPairs) ? MedianPairs : buf_fill - 1;
    for (int i = buf_fill - pairs; i < buf_fill; i++)
      if (buf_stamp[i] > buf_stamp[i - 1])
        deltas.push_back(64'(buf_stamp[i]) - 64'(buf_stamp[i - 1]));
    if (deltas.size() == 0) return dflt_period;
    deltas.sort();
    return deltas[deltas.size() / 2];
  endfunction

  function automatic void take(int idx, ref sel_sample_t res[$], ref logic [63:0] last_st);
    sel_sample_t s;
    if (res.size() > 0 && last_st == buf_stamp[idx]) return;
    if (res.size() >= MaxOut) return;
    s.stamp = buf_stamp[idx];
    s.w = buf_words[idx];
    s.empty = 1'b0;
    s.last = 1'b0;
    last_st = buf_stamp[idx];
    res.push_back(s);
  endfunction

  function automatic void select_window(imu_item_t it, ref sel_sample_t res[$]);
    logic signed [63:0] lo, hi;
    logic [63:0] per, mgn, last_st;
    int lo_idx, hi_idx, keep;
    sel_sample_t s;
    lo = (it.win_lo < 0) ? 64'sd0 : it.win_lo;
    hi = it.win_hi;
    lo_idx = -1; hi_idx = -1; keep = -1; last_st = '0;
    if (buf_fill > 0 && hi >= lo) begin
      per = median_period();
      mgn = per[63] ? '1 : per << 1;
      if (min_mgn > mgn) mgn = min_mgn;
      if (max_mgn != 0 && mgn > max_mgn) mgn = max_mgn;
      for (int i = 0; i < buf_fill; i++) begin
        if (buf_stamp[i] <= lo) lo_idx = i;
        if (buf_stamp[i] <= hi) keep = i;
        if (hi_idx < 0 && buf_stamp[i] > hi) hi_idx = i;
      end
      if (lo_idx >= 0 && 64'(lo) - 64'(buf_stamp[lo_idx]) <= mgn) take(lo_idx, res, last_st);
      for (int i = 0; i < buf_fill; i++)
        if (buf_stamp[i] > lo && buf_stamp[i] <= hi) take(i, res, last_st);
      if (hi_idx >= 0 && 64'(buf_stamp[hi_idx]) - 64'(hi) <= mgn) take(hi_idx, res, last_st);
      if (keep > 0) drop_oldest(keep);
    end
    if (res.size() == 0) begin
      s.stamp = '0;
      foreach (s.w[k]) s.w[k] = '0;
      s.empty = 1'b1;
      s.last = 1'b1;
      res.push_back(s);
    end else begin
      res[res.size() - 1].last = 1'b1;
    end
  endfunction

  task automatic write_reg(cfg_idx_e idx, logic [CfgW-1:0] val);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = val;
    case (idx)
      CFG_MIN_MARGIN:     min_mgn = 64'(val);
      CFG_MAX_MARGIN:     max_mgn = 64'(val);
      CFG_DEFAULT_PERIOD: dflt_period = 64'(val);
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // entered and left at a falling edge
  task automatic send_item(imu_item_t it, bit typed_empty);
    sel_sample_t res[$];
    sel_sample_t s;
    while (!no_gaps && $urandom_range(99) < 31) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    operation_i = it.op;
    sample_stamp_i = it.stamp;
    window_start_i = it.win_lo;
    window_end_i = it.win_hi;
    {acc_x_i, acc_y_i, acc_z_i, gyr_x_i, gyr_y_i, gyr_z_i} =
      {it.w[0], it.w[1], it.w[2], it.w[3], it.w[4], it.w[5]};
    do @(posedge clk_i); while (!in_ready_o);
    if (it.op == OP_ADD) begin
      store_sample(it);
      add_count++;
    end else begin
      select_window(it, res);
      assign_count++;
      if (typed_empty) begin
        // row expectation typed in: nothing selected
        s.stamp = '0;
        foreach (s.w[k]) s.w[k] = '0;
        s.empty = 1'b1;
        s.last = 1'b1;
        res = {s};
      end
      foreach (res[k]) pending_samples.push_back(res[k]);
    end
    @(negedge clk_i);
  endtask

  task automatic drain_and_idle();
    in_valid_i = 1'b0;
    while (pending_samples.size() > 0) @(negedge clk_i);
    repeat (150) @(negedge clk_i);
  endtask

  function automatic imu_item_t mk(bit op, logic [63:0] st, logic [63:0] lo, logic [63:0] hi,
                                   logic [31:0] fill_w);
    imu_item_t it;
    it.op = op;
    it.stamp = st;
    it.win_lo = lo;
    it.win_hi = hi;
    foreach (it.w[k]) it.w[k] = (fill_w == 32'h0 || fill_w == '1) ? fill_w : fill_w + k;
    return it;
  endfunction

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  // receiver side
  always @(negedge clk_i) begin : rx_side
    int hold_left;
    if (hold_go) begin
      hold_go <= 1'b0;
      hold_left = 600;
    end
    if (!rst_ni) out_ready_i <= 1'b0;
    else if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else out_ready_i <= no_gaps ? 1'b1 : ($urandom_range(99) >= 31);
  end

  // result checker
  always @(posedge clk_i) begin
    sel_sample_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      sample_count++;
      if (pending_samples.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: stamp %0d", out_stamp_o);
      end else begin
        e = pending_samples.pop_front();
        if (out_stamp_o !== e.stamp || out_acc_x_o !== e.w[0] || out_acc_y_o !== e.w[1] ||
            out_acc_z_o !== e.w[2] || out_gyr_x_o !== e.w[3] || out_gyr_y_o !== e.w[4] ||
            out_gyr_z_o !== e.w[5] || empty_result_o !== e.empty || last_of_run_o !== e.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp stamp %0d w %h %h %h %h %h %h e%b l%b / got %0d %h %h %h %h %h %h e%b l%b",
                     $signed(e.stamp), e.w[0], e.w[1], e.w[2], e.w[3], e.w[4], e.w[5], e.empty,
                     e.last, out_stamp_o, out_acc_x_o, out_acc_y_o, out_acc_z_o, out_gyr_x_o,
                     out_gyr_y_o, out_gyr_z_o, empty_result_o, last_of_run_o);
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    imu_item_t rows[$];
    bit typed[$];
    imu_item_t it;
    logic signed [63:0] t, per;
    int burst, sent;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed table
    rows.push_back(mk(OP_ASSIGN, 0, 0, 100, 0)); typed.push_back(1);
    rows.push_back(mk(OP_ADD, 64'h7fff_ffff_ffff_ffff, 0, 0, '1)); typed.push_back(0);
    rows.push_back(mk(OP_ADD, 64'h8000_0000_0000_0000, 0, 0, 0)); typed.push_back(0);
    rows.push_back(mk(OP_ADD, 0, 0, 0, 32'h1111_0000)); typed.push_back(0);
    rows.push_back(mk(OP_ADD, 1000, 0, 0, 32'h2222_0000)); typed.push_back(0);
    rows.push_back(mk(OP_ADD, 1000, 0, 0, 32'h3333_0000)); typed.push_back(0);
    rows.push_back(mk(OP_ADD, 2000, 0, 0, 32'h4444_0000)); typed.push_back(0);
    rows.push_back(mk(OP_ADD, 3000, 0, 0, 32'h5555_0000)); typed.push_back(0);
    rows.push_back(mk(OP_ASSIGN, 0, -5, 2500, 0)); typed.push_back(0);
    rows.push_back(mk(OP_ASSIGN, 0, 5000, 4000, 0)); typed.push_back(1);
    rows.push_back(mk(OP_ASSIGN, 0, 64'h8000_0000_0000_0000, -1, 0)); typed.push_back(0);
    rows.push_back(mk(OP_ADD, 64'h7fff_ffff_ffff_fff0, 0, 0, 32'hdead_0000)); typed.push_back(0);
    rows.push_back(mk(OP_ASSIGN, 0, 64'h7fff_ffff_ffff_fff0, 64'h7fff_ffff_ffff_ffff, 0));
    typed.push_back(0);
    rows.push_back(mk(OP_ASSIGN, 0, 64'h7fff_ffff_ffff_ffff, 64'h7fff_ffff_ffff_ffff, 0));
    typed.push_back(0);
    for (int i = 0; i < 34; i += 3) begin
      rows.push_back(mk(OP_ADD, 5000 + i * 7, 0, 0, 32'ha000_0000 + i)); typed.push_back(0);
    end
    rows.push_back(mk(OP_ASSIGN, 0, 0, 64'h7fff_ffff_ffff_ffff, 0)); typed.push_back(0);
    foreach (rows[i]) send_item(rows[i], typed[i]);
    drain_and_idle();

    // configuration phases
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          write_reg(CFG_MIN_MARGIN, '1);
          write_reg(CFG_MAX_MARGIN, '0);
          write_reg(CFG_DEFAULT_PERIOD, 40'd1);
          hold_go = 1'b1;
        end
        1: begin
          write_reg(CFG_MIN_MARGIN, '0);
          write_reg(CFG_MAX_MARGIN, 40'd1);
          write_reg(CFG_DEFAULT_PERIOD, '1);
        end
        2: begin
          write_reg(CFG_MIN_MARGIN, 40'd500);
          write_reg(CFG_MAX_MARGIN, '1);
          write_reg(CFG_DEFAULT_PERIOD, 40'd1000);
          no_gaps = 1'b1;
        end
        default: begin
          write_reg(CFG_MIN_MARGIN, 40'd3000);
          write_reg(CFG_MAX_MARGIN, 40'd20000);
          write_reg(CFG_DEFAULT_PERIOD, ResetPeriod);
          no_gaps = 1'b0;
        end
      endcase
      t = $signed(64'($urandom_range(6000))) - 3000;
      per = 64'($urandom_range(1, 2000));
      sent = 0;
      while (sent < 25) begin
        if ($urandom_range(9) == 0) begin
          // noise transaction
          it.op = $urandom_range(1);
          it.stamp = rnd64();
          it.win_lo = rnd64();
          it.win_hi = ($urandom_range(1)) ? rnd64() : it.win_lo + 64'($urandom);
          foreach (it.w[k]) it.w[k] = $urandom;
          send_item(it, 0);
          sent++;
        end else begin
          burst = (ph == 1 && sent == 0) ? 36 : $urandom_range(1, 6);
          for (int b = 0; b < burst; b++) begin
            case ($urandom_range(7))
              0: ;
              1: t = t - per;
              default: t = t + per + $signed(64'($urandom_range(per / 4 + 1)));
            endcase
            it.op = OP_ADD;
            it.stamp = t;
            it.win_lo = rnd64();
            it.win_hi = rnd64();
            foreach (it.w[k]) it.w[k] = $urandom;
            send_item(it, 0);
            sent++;
          end
          it.op = OP_ASSIGN;
          it.stamp = rnd64();
          it.win_lo = t - per * $urandom_range(0, 6);
          it.win_hi = it.win_lo + per * $urandom_range(0, 4) - $urandom_range(1);
          foreach (it.w[k]) it.w[k] = $urandom;
          send_item(it, 0);
          sent++;
        end
      end
      drain_and_idle();
    end

    repeat (200) @(posedge clk_i);
    $display("run covered %0d adds and %0d assigns, %0d selected samples checked",
             add_count, assign_count, sample_count);
    $display("margin settings included zero, full-scale and tight caps; %0d mismatches",
             mismatches);
    if (mismatches == 0 && pending_samples.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
